// File: design/bcr_pkg.sv
// Shared types and constants for the contiguous block relocator.
// Field widths, status and state encodings, register indexes, reset values.
// No dependencies.
`default_nettype none

package bcr_pkg;

	localparam int NUM_BLOCKS_DEF      = 1024;
	localparam int MAX_FILE_BLOCKS_DEF = 16;

	localparam int BLK_W   = 10;
	localparam int FDB_W   = 10;
	localparam int TOT_W   = 11;
	localparam int WORD_W  = 8;
	localparam int WORD_AW = 3;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [FDB_W-1:0] FDB_RST = 10'd3;
	localparam logic [TOT_W-1:0] TOT_RST = 11'd1024;

	localparam logic MODE_MAP = 1'b0;
	localparam logic REG_FDB  = 1'b0;
	localparam logic REG_TOT  = 1'b1;

	typedef enum logic [2:0] {
		STAT_LOADED  = 3'd0,
		STAT_SKIPPED = 3'd1,
		STAT_CONTIG  = 3'd2,
		STAT_NOSPACE = 3'd3,
		STAT_MOVED   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_NOSPACE,
		S_PLACE,
		S_FREE_PTR,
		S_MV_PTR,
		S_MV_OLD,
		S_MV_NEW
	} state_t;

endpackage

`default_nettype wire

// File: design/bitmap_contiguous_relocator.sv
// Top level of the contiguous block relocator: usage bitmap memory, pointer
// memory, first-fit scanner and relocation sequencer in one module.
// Depends on bcr_pkg.
//
// Usage: the item channel (item_valid/item_stall) carries map writes (mode 0)
// and file block pointers (mode 1, last marks the final pointer). The result
// channel (result_valid/result_stall) returns one beat per item, or one beat
// per file block when a file is moved; last_out marks the final beat.
// Map writes and pointers that are not last are handled in the idle state; the
// result shows in the output register on the next cycle. A final pointer that
// needs a search scans the bitmap memory one 8-bit word per cycle from the word of
// first_data_block to the word of the last block below the limit, then frees the
// old bit of each file block in turn, then sets the new run block by block,
// emitting each beat once the output register is free, all on one memory port.
// The block takes a new item only when idle and the output register is free or
// being drained, so a stalled receiver holds the block. After reset a clearing
// pass writes zero to every bitmap word, one word per cycle; no item is taken
// meanwhile. The APB port writes first_data_block (0x0) and the volume size
// (0x4); the user must write them only while idle, the block does not enforce it.
`default_nettype none

module bitmap_contiguous_relocator #(
	parameter int NUM_BLOCKS      = bcr_pkg::NUM_BLOCKS_DEF,
	parameter int MAX_FILE_BLOCKS = bcr_pkg::MAX_FILE_BLOCKS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bcr_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [bcr_pkg::DATA_W-1:0]   pwdata,
	output logic      [bcr_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire logic                         mode,
	input  wire logic [bcr_pkg::BLK_W-1:0]    block_index,
	input  wire logic                         used_flag,
	input  wire logic                         last,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic      [2:0]                   status,
	output logic      [bcr_pkg::BLK_W-1:0]    old_block,
	output logic      [bcr_pkg::BLK_W-1:0]    new_block,
	output logic                              last_out
);

	localparam int WORD_W = bcr_pkg::WORD_W;
	localparam int WAW    = bcr_pkg::WORD_AW;
	localparam int BLK_W  = bcr_pkg::BLK_W;
	localparam int NW     = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int AW     = (NW > 1) ? $clog2(NW) : 1;
	localparam int PW     = $clog2(NUM_BLOCKS + 1);
	localparam int CW     = (PW > BLK_W + 1) ? PW : BLK_W + 1;
	localparam int PAW    = $clog2(MAX_FILE_BLOCKS);
	localparam int CNTW   = $clog2(MAX_FILE_BLOCKS + 2);
	localparam int RW     = $clog2(MAX_FILE_BLOCKS + 1);

	bcr_pkg::state_t state_q, state_d;

	logic [bcr_pkg::FDB_W-1:0] fdb_q;
	logic [bcr_pkg::TOT_W-1:0] tot_q;

	logic [CNTW-1:0]  cnt_q;
	logic             contig_q;
	logic [BLK_W-1:0] prev_q;
	logic [RW-1:0]    len_q;
	logic [AW-1:0]    scan_q;
	logic [AW-1:0]    we_q;
	logic             iss_done_q;
	logic             valid_s1;
	logic [AW-1:0]    word_s1;
	logic [RW-1:0]    run_q;
	logic [PW-1:0]    endp_q;
	logic [PW-1:0]    start_q;
	logic [PAW-1:0]   j_q;
	logic [AW-1:0]    clr_q;

	logic                 out_valid_q;
	bcr_pkg::status_t     status_q;
	logic [BLK_W-1:0]     old_q;
	logic [BLK_W-1:0]     new_q;
	logic                 last_q;

	logic [WORD_W-1:0] umap_mem [NW];
	logic [WORD_W-1:0] u_rdata_q;
	logic              u_we;
	logic [AW-1:0]     u_waddr;
	logic [WORD_W-1:0] u_wmask;
	logic              u_wval;
	logic              u_re;

	logic [BLK_W-1:0]  ptr_mem [MAX_FILE_BLOCKS];
	logic [BLK_W-1:0]  ptr_rdata_q;
	logic              p_we;
	logic              p_re;

	logic             emit;
	bcr_pkg::status_t emit_status;
	logic [BLK_W-1:0] emit_old;
	logic [BLK_W-1:0] emit_new;
	logic             emit_last;

	logic             out_free;
	logic             item_acc;
	logic             cfg_wr;
	logic [PW-1:0]    lim;
	logic             seq_break;
	logic             contig_nx;
	logic [CNTW-1:0]  cnt_inc;
	logic             n_small;
	logic             ovf;
	logic             no_room;
	logic             idx_in;
	logic [PW-1:0]    pos_in;
	logic [PW-1:0]    old_pos;
	logic             old_in;
	logic [PW-1:0]    new_pos;
	logic             j_last;
	logic [AW-1:0]    ws;
	logic [AW-1:0]    we_v;
	logic [RW-1:0]    run_v;
	logic             found_v;
	logic [PW-1:0]    endp_v;

	assign pready       = 1'b1;
	assign cfg_wr       = psel && penable && pwrite && pready;
	assign out_free     = !out_valid_q || !result_stall;
	assign item_stall   = !((state_q == bcr_pkg::S_IDLE) && out_free);
	assign item_acc     = item_valid && !item_stall;

	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign old_block    = old_q;
	assign new_block    = new_q;
	assign last_out     = last_q;

	assign lim = (CW'(tot_q) < CW'(NUM_BLOCKS)) ? PW'(tot_q) : PW'(NUM_BLOCKS);

	assign seq_break = (cnt_q != '0) &&
		({1'b0, block_index} != ({1'b0, prev_q} + (BLK_W + 1)'(1)));
	assign contig_nx = contig_q && !seq_break;
	assign cnt_inc   = (cnt_q <= CNTW'(MAX_FILE_BLOCKS)) ? cnt_q + CNTW'(1) : cnt_q;
	assign n_small   = cnt_inc <= CNTW'(1);
	assign ovf       = cnt_inc > CNTW'(MAX_FILE_BLOCKS);
	assign no_room   = CW'(fdb_q) >= CW'(lim);
	assign idx_in    = CW'(block_index) < CW'(NUM_BLOCKS);
	assign pos_in    = PW'(block_index);
	assign old_pos   = PW'(ptr_rdata_q);
	assign old_in    = CW'(ptr_rdata_q) < CW'(NUM_BLOCKS);
	assign new_pos   = start_q + PW'(j_q);
	assign j_last    = (RW'(j_q) + RW'(1)) == len_q;
	assign ws        = AW'(fdb_q >> WAW);
	assign we_v      = AW'((lim - PW'(1)) >> WAW);

	// register file
	always_comb begin
		case (paddr[2])
			bcr_pkg::REG_FDB: prdata = bcr_pkg::DATA_W'(fdb_q);
			bcr_pkg::REG_TOT: prdata = bcr_pkg::DATA_W'(tot_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fdb_q <= bcr_pkg::FDB_RST;
			tot_q <= bcr_pkg::TOT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				bcr_pkg::REG_FDB: fdb_q <= pwdata[bcr_pkg::FDB_W-1:0];
				bcr_pkg::REG_TOT: tot_q <= pwdata[bcr_pkg::TOT_W-1:0];
				default:          fdb_q <= fdb_q;
			endcase
		end
	end

	// bitmap memory, bit write enables, one read port
	always_ff @(posedge clk) begin
		if (u_we) begin
			for (int b = 0; b < WORD_W; b++) begin
				if (u_wmask[b]) begin
					umap_mem[u_waddr][b] <= u_wval;
				end
			end
		end
		if (u_re) begin
			u_rdata_q <= umap_mem[scan_q];
		end
	end

	// pointer memory
	always_ff @(posedge clk) begin
		if (p_we) begin
			ptr_mem[cnt_q[PAW-1:0]] <= block_index;
		end
		if (p_re) begin
			ptr_rdata_q <= ptr_mem[j_q];
		end
	end

	// first-fit run count across one bitmap word
	always_comb begin
		logic [CW-1:0] pos_v;
		logic          inr;
		run_v   = run_q;
		found_v = 1'b0;
		endp_v  = '0;
		for (int b = 0; b < WORD_W; b++) begin
			pos_v = CW'({word_s1, WAW'(b)});
			inr   = (pos_v >= CW'(fdb_q)) && (pos_v < CW'(lim));
			if (!found_v) begin
				if (inr && !u_rdata_q[b]) begin
					run_v = run_v + RW'(1);
					if (run_v == len_q) begin
						found_v = 1'b1;
						endp_v  = PW'(pos_v);
					end
				end else begin
					run_v = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcr_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		u_we        = 1'b0;
		u_waddr     = '0;
		u_wmask     = '0;
		u_wval      = 1'b0;
		u_re        = 1'b0;
		p_we        = 1'b0;
		p_re        = 1'b0;
		emit        = 1'b0;
		emit_status = bcr_pkg::STAT_LOADED;
		emit_old    = '0;
		emit_new    = '0;
		emit_last   = 1'b1;
		case (state_q)
			bcr_pkg::S_CLEAR: begin
				u_we    = 1'b1;
				u_waddr = clr_q;
				u_wmask = '1;
				if (clr_q == AW'(NW - 1)) begin
					state_d = bcr_pkg::S_IDLE;
				end
			end
			bcr_pkg::S_IDLE: begin
				if (item_acc) begin
					emit = 1'b1;
					if (mode == bcr_pkg::MODE_MAP) begin
						u_we    = idx_in;
						u_waddr = pos_in[AW+WAW-1:WAW];
						u_wmask = WORD_W'(1) << pos_in[WAW-1:0];
						u_wval  = used_flag;
					end else begin
						p_we = cnt_q < CNTW'(MAX_FILE_BLOCKS);
						if (last) begin
							if (n_small) begin
								emit_status = bcr_pkg::STAT_SKIPPED;
							end else if (contig_nx) begin
								emit_status = bcr_pkg::STAT_CONTIG;
							end else if (ovf || no_room) begin
								emit_status = bcr_pkg::STAT_NOSPACE;
							end else begin
								emit    = 1'b0;
								state_d = bcr_pkg::S_SCAN;
							end
						end
					end
				end
			end
			bcr_pkg::S_SCAN: begin
				u_re = !iss_done_q;
				if (valid_s1) begin
					if (found_v) begin
						state_d = bcr_pkg::S_PLACE;
					end else if (word_s1 == we_q) begin
						state_d = bcr_pkg::S_NOSPACE;
					end
				end
			end
			bcr_pkg::S_NOSPACE: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_status = bcr_pkg::STAT_NOSPACE;
					state_d     = bcr_pkg::S_IDLE;
				end
			end
			bcr_pkg::S_PLACE: begin
				state_d = bcr_pkg::S_FREE_PTR;
			end
			bcr_pkg::S_FREE_PTR: begin
				p_re    = 1'b1;
				state_d = bcr_pkg::S_MV_OLD;
			end
			bcr_pkg::S_MV_OLD: begin
				u_we    = old_in;
				u_waddr = old_pos[AW+WAW-1:WAW];
				u_wmask = WORD_W'(1) << old_pos[WAW-1:0];
				u_wval  = 1'b0;
				state_d = j_last ? bcr_pkg::S_MV_PTR : bcr_pkg::S_FREE_PTR;
			end
			bcr_pkg::S_MV_PTR: begin
				p_re    = 1'b1;
				state_d = bcr_pkg::S_MV_NEW;
			end
			bcr_pkg::S_MV_NEW: begin
				if (out_free) begin
					u_we        = 1'b1;
					u_waddr     = new_pos[AW+WAW-1:WAW];
					u_wmask     = WORD_W'(1) << new_pos[WAW-1:0];
					u_wval      = 1'b1;
					emit        = 1'b1;
					emit_status = bcr_pkg::STAT_MOVED;
					emit_old    = ptr_rdata_q;
					emit_new    = BLK_W'(new_pos);
					emit_last   = j_last;
					state_d     = j_last ? bcr_pkg::S_IDLE : bcr_pkg::S_MV_PTR;
				end
			end
			default: begin
				state_d = bcr_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			contig_q   <= 1'b1;
			prev_q     <= '0;
			len_q      <= '0;
			scan_q     <= '0;
			we_q       <= '0;
			iss_done_q <= 1'b0;
			valid_s1   <= 1'b0;
			word_s1    <= '0;
			run_q      <= '0;
			endp_q     <= '0;
			start_q    <= '0;
			j_q        <= '0;
			clr_q      <= '0;
		end else begin
			valid_s1 <= u_re;
			word_s1  <= scan_q;
			case (state_q)
				bcr_pkg::S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				bcr_pkg::S_IDLE: begin
					if (item_acc && (mode != bcr_pkg::MODE_MAP)) begin
						prev_q <= block_index;
						if (last) begin
							cnt_q      <= '0;
							contig_q   <= 1'b1;
							len_q      <= RW'(cnt_inc);
							scan_q     <= ws;
							we_q       <= we_v;
							iss_done_q <= 1'b0;
							run_q      <= '0;
						end else begin
							cnt_q    <= cnt_inc;
							contig_q <= contig_nx;
						end
					end
				end
				bcr_pkg::S_SCAN: begin
					if (u_re) begin
						if (scan_q == we_q) begin
							iss_done_q <= 1'b1;
						end else begin
							scan_q <= scan_q + AW'(1);
						end
					end
					if (valid_s1) begin
						run_q <= run_v;
						if (found_v) begin
							endp_q <= endp_v;
						end
					end
				end
				bcr_pkg::S_PLACE: begin
					start_q <= endp_q - PW'(len_q) + PW'(1);
					j_q     <= '0;
				end
				bcr_pkg::S_MV_OLD: begin
					j_q <= j_last ? '0 : j_q + PAW'(1);
				end
				bcr_pkg::S_MV_NEW: begin
					if (out_free) begin
						j_q <= j_q + PAW'(1);
					end
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= emit_status;
			old_q    <= emit_old;
			new_q    <= emit_new;
			last_q   <= emit_last;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(MAX_FILE_BLOCKS + 1))
		else $error("pointer count past its bound");

	a_move_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bcr_pkg::S_MV_NEW) |-> (RW'(j_q) < len_q))
		else $error("move index past file length");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status != bcr_pkg::STAT_MOVED)) |-> last_out)
		else $error("single-beat result without last_out");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bcr_pkg::S_CLEAR) |=> !(emit && (state_q == bcr_pkg::S_CLEAR)))
		else $error("result during clearing pass");
`endif

endmodule

`default_nettype wire
